@@ hdl/mvdi_pkg.sv @@
// Shared types, sizes and helpers for the mesh vertex dedup indexer.
// No dependencies; imported by mvdi_ctrl, mvdi_datapath and the top level.
`default_nettype none

package mvdi_pkg;

  localparam int MAX_UNIQUE       = 256;
  localparam int WORDS_PER_VERTEX = 11;
  localparam int WORD_W           = 32;
  localparam int VERTEX_W         = WORDS_PER_VERTEX * WORD_W;
  localparam int ADDR_W           = (MAX_UNIQUE > 1) ? $clog2(MAX_UNIQUE) : 1;
  localparam int COUNT_W          = $clog2(MAX_UNIQUE + 1);

  localparam int IDX_W   = 8;
  localparam int TOTAL_W = 9;
  localparam int IDX_SAT   = 255;
  localparam int TOTAL_SAT = 511;

  localparam int S_TDATA_W = ((VERTEX_W + 7) / 8) * 8;
  localparam int M_FIELD_W = IDX_W + 1 + 1 + TOTAL_W;
  localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

  typedef struct packed {
    logic accept;   // latch the incoming vertex, apply new_mesh
    logic scan;     // walk the stored entries
    logic resolve;  // commit result, append if needed
  } ctrl_cmd_t;

  typedef struct packed {
    logic hit;        // current compare matched
    logic exhausted;  // every stored entry compared, no match
    logic out_free;   // output register can take a result
  } dp_status_t;

  function automatic logic [IDX_W-1:0] sat_index(input logic [COUNT_W-1:0] v);
    if (v > COUNT_W'(IDX_SAT)) begin
      return IDX_W'(IDX_SAT);
    end
    return IDX_W'(v);
  endfunction

  function automatic logic [TOTAL_W-1:0] sat_total(input logic [COUNT_W-1:0] v);
    if (v > COUNT_W'(TOTAL_SAT)) begin
      return TOTAL_W'(TOTAL_SAT);
    end
    return TOTAL_W'(v);
  endfunction

endpackage

`default_nettype wire

@@ hdl/mvdi_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mvdi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/mvdi_datapath.sv @@
// Datapath: vertex holding register, entry table RAM, scan pointer,
// compare, append logic and output register. Depends on mvdi_pkg, mvdi_ram.
`default_nettype none

module mvdi_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire mvdi_pkg::ctrl_cmd_t             cmd,
  output mvdi_pkg::dp_status_t                 status,
  input  wire logic [mvdi_pkg::S_TDATA_W-1:0]  s_tdata,
  input  wire logic                            s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic      [mvdi_pkg::M_TDATA_W-1:0]  m_tdata
);
  import mvdi_pkg::*;

  logic [VERTEX_W-1:0] vtx;
  logic [COUNT_W-1:0]  count;
  logic [COUNT_W-1:0]  rd_ptr;
  logic                cmp_valid;
  logic [ADDR_W-1:0]   cmp_idx;
  logic                hit_flag;
  logic [ADDR_W-1:0]   hit_idx;
  logic [VERTEX_W-1:0] rd_data;
  logic                ram_we;
  logic                room;

  logic [IDX_W-1:0]    res_idx;
  logic                res_added;
  logic                res_ovf;
  logic [TOTAL_W-1:0]  res_total;

  assign room   = (count < COUNT_W'(MAX_UNIQUE));
  assign ram_we = cmd.resolve && !hit_flag && room;

  mvdi_ram #(
    .WIDTH(VERTEX_W),
    .DEPTH(MAX_UNIQUE)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count[ADDR_W-1:0]),
    .wdata(vtx),
    .raddr(rd_ptr[ADDR_W-1:0]),
    .rdata(rd_data)
  );

  assign status.hit       = cmp_valid && (rd_data == vtx);
  assign status.exhausted = !cmp_valid && (rd_ptr == count);
  assign status.out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      vtx <= s_tdata[VERTEX_W-1:0];
    end
    if (cmd.accept) begin
      rd_ptr    <= '0;
      cmp_valid <= 1'b0;
      hit_flag  <= 1'b0;
    end else if (cmd.scan) begin
      if (status.hit) begin
        hit_flag <= 1'b1;
        hit_idx  <= cmp_idx;
      end
      if (rd_ptr < count) begin
        rd_ptr    <= rd_ptr + COUNT_W'(1);
        cmp_valid <= 1'b1;
        cmp_idx   <= rd_ptr[ADDR_W-1:0];
      end else begin
        cmp_valid <= 1'b0;
      end
    end
    if (cmd.resolve) begin
      res_added <= 1'b0;
      res_ovf   <= 1'b0;
      res_total <= sat_total(count);
      if (hit_flag) begin
        res_idx <= sat_index(COUNT_W'(hit_idx));
      end else if (room) begin
        res_idx   <= sat_index(count);
        res_added <= 1'b1;
        res_total <= sat_total(count + COUNT_W'(1));
      end else begin
        res_idx <= sat_index(count);
        res_ovf <= 1'b1;
      end
    end
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.accept && s_tuser) begin
        count <= '0;
      end else if (ram_we) begin
        count <= count + COUNT_W'(1);
      end
      if (cmd.resolve) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {(M_TDATA_W - M_FIELD_W)'(0), res_total, res_ovf, res_added, res_idx};

endmodule

`default_nettype wire

@@ hdl/mvdi_ctrl.sv @@
// Controller state machine: sequences accept, table scan and result commit.
// Depends on mvdi_pkg.
`default_nettype none

module mvdi_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire mvdi_pkg::dp_status_t status,
  output mvdi_pkg::ctrl_cmd_t       cmd
);
  import mvdi_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_SCAN    = 3'b010,
    ST_RESOLVE = 3'b100
  } state_t;

  state_t state, state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next  = state;
    cmd         = '0;
    case (state)
      ST_IDLE: begin
        cmd.accept = s_tvalid;
        if (s_tvalid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.hit || status.exhausted) begin
          state_next = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        // hold until the output register is free
        if (status.out_free) begin
          cmd.resolve = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/mesh_vertex_dedup_indexer.sv @@
// Top level of the mesh vertex dedup indexer: controller plus datapath.
// Depends on mvdi_pkg, mvdi_ctrl, mvdi_datapath (and mvdi_ram below it).
//
//  channel  dir  width  beat contents
//  s_*      in   352+1  one vertex (eleven float words) and the new_mesh flag
//  m_*      out  24     index, added flag, overflow flag, unique total
//
// Sequence: an item is accepted, the stored entries are read and compared in turn
//   behind the RAM read latency, the end of the table is seen, and the result is
//   committed; a hit ends the scan early at the matching entry.
// The single read port of the entry table sets the rate: one entry a cycle.
// Reset (rst, synchronous) empties the table count and drops any pending
//   result; table contents are not cleared, only entries below the count are read.
// A stalled output holds the result; the next beat is still taken on s_*
//   and its scan runs, waiting only at commit for the output register.
`default_nettype none

module mesh_vertex_dedup_indexer (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z, tan_x, tan_y, tan_z
  input  wire logic [mvdi_pkg::S_TDATA_W-1:0]  s_tdata,
  // new_mesh
  input  wire logic                            s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // vertex_index[7:0], newly_added[8], table_overflow[9], unique_total[18:10]
  output logic      [mvdi_pkg::M_TDATA_W-1:0]  m_tdata
);
  import mvdi_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  mvdi_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .status  (status),
    .cmd     (cmd)
  );

  mvdi_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .status  (status),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  // one item in flight: after an accept the input side closes
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an item is in flight");

  // an appended vertex cannot also report overflow
  a_add_xor_ovf: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[IDX_W] && m_tdata[IDX_W+1]))
    else $error("newly_added and table_overflow both set");

  // an appended vertex is the last entry of the table
  a_add_index: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[IDX_W]) |->
      (m_tdata[M_FIELD_W-1:IDX_W+2] == (TOTAL_W'(m_tdata[IDX_W-1:0]) + TOTAL_W'(1))))
    else $error("appended index does not match unique total");

  // a commit only happens when the output register is free
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.resolve |-> status.out_free)
    else $error("result committed over a pending output beat");

endmodule

`default_nettype wire
